// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the stack control RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ILS_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("ils assertion failed");

// When ante holds, cons must hold in the next cycle.
`define ILS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ils assertion failed");

`endif

// ===== rtl/core/ils_pkg.sv =====
// Types and constants for the indexed LIFO stack.
package ils_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic [DATA_W-1:0] t_word;

    typedef enum logic [3:0] {
        OP_PUSH         = 4'd0,
        OP_POP          = 4'd1,
        OP_PEEK         = 4'd2,
        OP_READ         = 4'd3,
        OP_WRITE        = 4'd4,
        OP_INSERT       = 4'd5,
        OP_REMOVE_AT    = 4'd6,
        OP_FIND         = 4'd7,
        OP_REMOVE_MATCH = 4'd8
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_ABOVE = 2'd2,
        CELL_FROM_BELOW = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [4:0]  position;
        logic [31:0] item_value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_value;
        logic [3:0]  found_position;
        logic [4:0]  entry_total;
    } t_rsp;

endpackage

// ===== rtl/core/ils_cell.sv =====
// One storage cell of the stack chain with its own equality compare.
module ils_cell (
    input  logic              i_clk,
    input  ils_pkg::t_cell_op i_op,
    input  ils_pkg::t_word    i_load,
    input  ils_pkg::t_word    i_above,
    input  ils_pkg::t_word    i_below,
    input  ils_pkg::t_word    i_key,
    output ils_pkg::t_word    o_data,
    output logic              o_match
);

    ils_pkg::t_word r_data;
    ils_pkg::t_word n_data;

    always_comb begin
        case (i_op)
            ils_pkg::CELL_HOLD:       n_data = r_data;
            ils_pkg::CELL_LOAD:       n_data = i_load;
            ils_pkg::CELL_FROM_ABOVE: n_data = i_above;
            ils_pkg::CELL_FROM_BELOW: n_data = i_below;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

// ===== rtl/core/ils_ctrl.sv =====
// Request decode, entry count and per-cell shift control for the stack.
`include "assert_macros.svh"

module ils_ctrl (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_fire,
    input  ils_pkg::t_req                          i_req,
    input  ils_pkg::t_word   [ils_pkg::DEPTH-1:0]  i_cell_data,
    input  logic             [ils_pkg::DEPTH-1:0]  i_match,
    output ils_pkg::t_cell_op [ils_pkg::DEPTH-1:0] o_cell_op,
    output ils_pkg::t_word                         o_load_data,
    output ils_pkg::t_rsp                          o_rsp
);

    logic [ils_pkg::CNT_W-1:0] r_count;
    logic [ils_pkg::CNT_W-1:0] n_count;

    logic [ils_pkg::DEPTH-1:0] hit;
    logic [ils_pkg::DEPTH-1:0] load_vec;
    logic [ils_pkg::IDX_W-1:0] first_idx;
    logic                      any_hit;
    logic [ils_pkg::IDX_W-1:0] idx;
    logic [ils_pkg::IDX_W-1:0] tgt;
    logic                      do_open;
    logic                      do_close;
    logic                      do_write;
    logic                      full;
    logic                      in_range;
    ils_pkg::t_status          status;
    ils_pkg::t_word            res;
    logic [ils_pkg::IDX_W-1:0] fpos;

    assign idx      = i_req.position[ils_pkg::IDX_W-1:0];
    assign full     = (r_count >= ils_pkg::CNT_W'(ils_pkg::DEPTH));
    assign in_range = (ils_pkg::CNT_W'(i_req.position) < r_count);

    // First live cell whose word equals the key; top wins.
    always_comb begin
        first_idx = '0;
        any_hit   = 1'b0;
        for (int i = ils_pkg::DEPTH - 1; i >= 0; i--) begin
            hit[i] = i_match[i] && (ils_pkg::CNT_W'(i) < r_count);
            if (hit[i]) begin
                first_idx = ils_pkg::IDX_W'(i);
                any_hit   = 1'b1;
            end
        end
    end

    always_comb begin
        status   = ils_pkg::ST_OK;
        res      = '0;
        fpos     = '0;
        tgt      = '0;
        do_open  = 1'b0;
        do_close = 1'b0;
        do_write = 1'b0;
        n_count  = r_count;
        case (i_req.opcode)
            ils_pkg::OP_PUSH: begin
                if (full) begin
                    status = ils_pkg::ST_FULL;
                end else begin
                    do_open = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ils_pkg::OP_POP, ils_pkg::OP_PEEK: begin
                if (r_count == '0) begin
                    status = ils_pkg::ST_RANGE;
                end else begin
                    res = i_cell_data[0];
                    if (i_req.opcode == ils_pkg::OP_POP) begin
                        do_close = 1'b1;
                        n_count  = r_count - 1'b1;
                    end
                end
            end
            ils_pkg::OP_READ, ils_pkg::OP_WRITE, ils_pkg::OP_REMOVE_AT: begin
                tgt = idx;
                if (!in_range) begin
                    status = ils_pkg::ST_RANGE;
                end else if (i_req.opcode == ils_pkg::OP_READ) begin
                    res = i_cell_data[idx];
                end else if (i_req.opcode == ils_pkg::OP_WRITE) begin
                    do_write = 1'b1;
                end else begin
                    res      = i_cell_data[idx];
                    do_close = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            ils_pkg::OP_INSERT: begin
                tgt = idx;
                if (full) begin
                    status = ils_pkg::ST_FULL;
                end else if (ils_pkg::CNT_W'(i_req.position) > r_count) begin
                    status = ils_pkg::ST_RANGE;
                end else begin
                    do_open = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ils_pkg::OP_FIND, ils_pkg::OP_REMOVE_MATCH: begin
                tgt = first_idx;
                if (!any_hit) begin
                    status = ils_pkg::ST_NOT_FOUND;
                end else if (i_req.opcode == ils_pkg::OP_FIND) begin
                    fpos = first_idx;
                end else begin
                    res      = i_cell_data[first_idx];
                    do_close = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                status = ils_pkg::ST_RANGE;
            end
        endcase
    end

    // Open a gap: cells below the target take from above. Close: take from below.
    always_comb begin
        for (int i = 0; i < ils_pkg::DEPTH; i++) begin
            o_cell_op[i] = ils_pkg::CELL_HOLD;
            load_vec[i]  = 1'b0;
            if (i_fire) begin
                if (do_open && (ils_pkg::IDX_W'(i) > tgt)) begin
                    o_cell_op[i] = ils_pkg::CELL_FROM_ABOVE;
                end else if ((do_open || do_write) && (ils_pkg::IDX_W'(i) == tgt)) begin
                    o_cell_op[i] = ils_pkg::CELL_LOAD;
                    load_vec[i]  = 1'b1;
                end else if (do_close && (ils_pkg::IDX_W'(i) >= tgt)) begin
                    o_cell_op[i] = ils_pkg::CELL_FROM_BELOW;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    assign o_load_data         = i_req.item_value;
    assign o_rsp.status        = status;
    assign o_rsp.result_value  = res;
    assign o_rsp.found_position = fpos;
    assign o_rsp.entry_total   = n_count;

    `ILS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= ils_pkg::CNT_W'(ils_pkg::DEPTH))
    `ILS_ASSERT_ALWAYS(a_one_load, i_clk, i_rst_n, $onehot0(load_vec))
    `ILS_ASSERT_NEXT(a_fail_keeps, i_clk, i_rst_n, i_fire && (status != ils_pkg::ST_OK),
        r_count == $past(r_count))
    `ILS_ASSERT_NEXT(a_open_grows, i_clk, i_rst_n, i_fire && do_open,
        r_count == $past(r_count) + 1'b1)

endmodule

// ===== rtl/core/indexed_lifo_stack.sv =====
// Indexed LIFO stack: top level with the cell chain and output register.
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries one request item (opcode,
//   position, item_value). Output channel o_out_valid/i_out_ready carries one
//   response item (status, result_value, found_position, entry_total) for
//   every request, in request order.
//   Storage is a row of DEPTH cells; position 0 is the top. Push and insert
//   shift the cells below the target down one place, pop and removals shift
//   them up, all at the clock edge at which the request is taken. Find
//   compares every cell in parallel and picks the topmost live match.
//   Latency: the response is valid the cycle after the request is accepted.
//   Throughput: one request per cycle while responses are taken, set by the
//   update of the cell row at the accepting edge and the one-deep output register.
//   Stall: while a response is held and i_out_ready is low, o_in_ready is low
//   and the stack does not change; taking the response frees the register in
//   the same cycle that a new request is accepted.
//   Reset: synchronous, active low; the entry count clears to zero and the
//   output register empties. Cell contents are not cleared.
module indexed_lifo_stack (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ils_pkg::t_req  i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ils_pkg::t_rsp  o_out_item
);

    ils_pkg::t_word    [ils_pkg::DEPTH-1:0] cell_data;
    logic              [ils_pkg::DEPTH-1:0] cell_match;
    ils_pkg::t_cell_op [ils_pkg::DEPTH-1:0] cell_op;
    ils_pkg::t_word                         load_data;
    ils_pkg::t_rsp                          rsp;
    logic                                   fire;

    logic          r_out_valid;
    ils_pkg::t_rsp r_out_item;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;

    ils_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_req       (i_in_item),
        .i_cell_data (cell_data),
        .i_match     (cell_match),
        .o_cell_op   (cell_op),
        .o_load_data (load_data),
        .o_rsp       (rsp)
    );

    for (genvar g = 0; g < ils_pkg::DEPTH; g++) begin : g_cell
        ils_pkg::t_word above;
        ils_pkg::t_word below;
        if (g == 0) begin : g_top
            assign above = '0;
        end else begin : g_mid_a
            assign above = cell_data[g-1];
        end
        if (g == ils_pkg::DEPTH - 1) begin : g_bot
            assign below = '0;
        end else begin : g_mid_b
            assign below = cell_data[g+1];
        end
        ils_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op[g]),
            .i_load  (load_data),
            .i_above (above),
            .i_below (below),
            .i_key   (i_in_item.item_value),
            .o_data  (cell_data[g]),
            .o_match (cell_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== verif/tb_indexed_lifo_stack.sv =====
// Testbench for the indexed LIFO stack: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module tb_indexed_lifo_stack;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 250;

    typedef struct {
        ils_pkg::t_req req;
        bit            wait_idle;
    } t_stim;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    ils_pkg::t_req  in_item = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    ils_pkg::t_rsp  out_item;

    t_stim         requests_q[$];
    ils_pkg::t_rsp answers_due[$];
    int    sent_cnt = 0;
    int    recv_cnt = 0;
    int    errors = 0;
    int    gap_left = 0;
    int    stall_left = 0;
    int    hold_left = 0;
    bit    hold_done = 1'b0;

    // predictor copy of the stack
    ils_pkg::t_word stack_words [ils_pkg::DEPTH];
    int unsigned    stack_fill = 0;

    ils_pkg::t_word value_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                       32'h8000_0000, 32'h1234_5678, 32'hA5A5_A5A5};

    indexed_lifo_stack DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void open_gap(input int unsigned pos);
        for (int unsigned i = stack_fill; i > pos; i--) begin
            stack_words[i] = stack_words[i-1];
        end
        stack_fill++;
    endfunction

    function automatic void close_gap(input int unsigned pos);
        for (int unsigned i = pos; i + 1 < stack_fill; i++) begin
            stack_words[i] = stack_words[i+1];
        end
        stack_fill--;
    endfunction

    function automatic ils_pkg::t_rsp apply_to_stack(input ils_pkg::t_req req);
        ils_pkg::t_rsp  rsp;
        int unsigned    pos;
        int unsigned    hit;
        ils_pkg::t_word v;
        rsp = '0;
        pos = req.position;
        v   = req.item_value;
        case (ils_pkg::t_opcode'(req.opcode))
            ils_pkg::OP_PUSH: begin
                if (stack_fill >= ils_pkg::DEPTH) begin
                    rsp.status = ils_pkg::ST_FULL;
                end else begin
                    open_gap(0);
                    stack_words[0] = v;
                end
            end
            ils_pkg::OP_POP, ils_pkg::OP_PEEK: begin
                if (stack_fill == 0) begin
                    rsp.status = ils_pkg::ST_RANGE;
                end else begin
                    rsp.result_value = stack_words[0];
                    if (req.opcode == ils_pkg::OP_POP) close_gap(0);
                end
            end
            ils_pkg::OP_READ, ils_pkg::OP_WRITE, ils_pkg::OP_REMOVE_AT: begin
                if (pos >= stack_fill) begin
                    rsp.status = ils_pkg::ST_RANGE;
                end else if (req.opcode == ils_pkg::OP_READ) begin
                    rsp.result_value = stack_words[pos];
                end else if (req.opcode == ils_pkg::OP_WRITE) begin
                    stack_words[pos] = v;
                end else begin
                    rsp.result_value = stack_words[pos];
                    close_gap(pos);
                end
            end
            ils_pkg::OP_INSERT: begin
                // full wins over a bad position
                if (stack_fill >= ils_pkg::DEPTH) begin
                    rsp.status = ils_pkg::ST_FULL;
                end else if (pos > stack_fill) begin
                    rsp.status = ils_pkg::ST_RANGE;
                end else begin
                    open_gap(pos);
                    stack_words[pos] = v;
                end
            end
            ils_pkg::OP_FIND, ils_pkg::OP_REMOVE_MATCH: begin
                hit = ils_pkg::DEPTH;
                for (int unsigned i = 0; i < stack_fill; i++) begin
                    if (hit == ils_pkg::DEPTH && stack_words[i] == v) hit = i;
                end
                if (hit == ils_pkg::DEPTH) begin
                    rsp.status = ils_pkg::ST_NOT_FOUND;
                end else if (req.opcode == ils_pkg::OP_FIND) begin
                    rsp.found_position = hit[3:0];
                end else begin
                    rsp.result_value = stack_words[hit];
                    close_gap(hit);
                end
            end
            default: rsp.status = ils_pkg::ST_RANGE;
        endcase
        rsp.entry_total = stack_fill[4:0];
        return rsp;
    endfunction

    function automatic void add_request(input logic [3:0] op, input int unsigned pos,
                                        input ils_pkg::t_word v, input bit wait_idle = 1'b0);
        t_stim s;
        s.req.opcode     = op;
        s.req.position   = pos[4:0];
        s.req.item_value = v;
        s.wait_idle      = wait_idle;
        requests_q.push_back(s);
    endfunction

    function automatic ils_pkg::t_word pick_value();
        if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    // mostly short gaps, a few long ones, and whole stretches with none
    function automatic int pick_gap(input int seq_cnt);
        int r;
        r = $urandom_range(0, 99);
        if ((seq_cnt / 150) % 4 == 1) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sender
    always @(posedge clk) begin : drive_requests
        bit    took;
        bit    offer;
        t_stim nxt;
        took  = in_valid && in_ready;
        offer = 1'b0;
        if (rst_n) begin
            if (took) begin
                answers_due.push_back(apply_to_stack(in_item));
                sent_cnt <= sent_cnt + 1;
            end
            if (!in_valid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (requests_q.size() > 0 &&
                             (!requests_q[0].wait_idle || (!took && sent_cnt == recv_cnt))) begin
                    nxt = requests_q.pop_front();
                    in_item  <= nxt.req;
                    offer    = 1'b1;
                    gap_left = pick_gap(sent_cnt);
                end
                in_valid <= offer;
            end
        end
    end

    // receiver and checker
    always @(posedge clk) begin : check_answers
        ils_pkg::t_rsp want;
        bit            ready_nxt;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (sent_cnt == recv_cnt) begin
                    $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    recv_cnt <= recv_cnt + 1;
                    if (out_item.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, out_item.status);
                        errors++;
                    end
                    if (out_item.result_value !== want.result_value) begin
                        $display("%0t: result_value expected %h actual %h",
                                 $time, want.result_value, out_item.result_value);
                        errors++;
                    end
                    if (out_item.found_position !== want.found_position) begin
                        $display("%0t: found_position expected %0d actual %0d",
                                 $time, want.found_position, out_item.found_position);
                        errors++;
                    end
                    if (out_item.entry_total !== want.entry_total) begin
                        $display("%0t: entry_total expected %0d actual %0d",
                                 $time, want.entry_total, out_item.entry_total);
                        errors++;
                    end
                end
            end
            ready_nxt = 1'b1;
            if (hold_left > 0) begin
                hold_left--;
                ready_nxt = 1'b0;
            end else if (!hold_done && recv_cnt == HOLD_AT) begin
                // long back-pressure while the sender keeps offering
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                ready_nxt = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_nxt = 1'b0;
            end else begin
                stall_left = pick_gap(recv_cnt + 75);
                ready_nxt  = (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
            out_ready <= ready_nxt;
        end
    end

    initial begin
        for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
        $display("tb_indexed_lifo_stack: FAIL");
        $finish;
    end

    initial begin
        int          n;
        int          kind;
        int          len;
        int          r;
        logic [3:0]  op;
        int unsigned pos;

        // empty stack corner cases
        add_request(ils_pkg::OP_POP, 0, '0);
        add_request(ils_pkg::OP_PEEK, 0, '0);
        add_request(ils_pkg::OP_READ, 0, '0);
        add_request(ils_pkg::OP_WRITE, 0, 32'h5555_5555);
        add_request(ils_pkg::OP_REMOVE_AT, 0, '0);
        add_request(ils_pkg::OP_FIND, 0, '0);
        add_request(ils_pkg::OP_REMOVE_MATCH, 0, '0);
        add_request(ils_pkg::OP_INSERT, 1, 32'h0000_0007);
        add_request(4'(int'(ils_pkg::OP_REMOVE_MATCH) + 1), 0, '0);
        add_request('1, 31, '1);
        // small stack: append, insert on top, bad and bottom positions
        add_request(ils_pkg::OP_PUSH, 0, 32'hFFFF_FFFF);
        add_request(ils_pkg::OP_PUSH, 0, 32'h0000_0000);
        add_request(ils_pkg::OP_INSERT, 2, 32'h0000_0001);
        add_request(ils_pkg::OP_INSERT, 0, 32'h8000_0000);
        add_request(ils_pkg::OP_READ, 31, '0);
        add_request(ils_pkg::OP_READ, 3, '0);
        add_request(ils_pkg::OP_WRITE, 1, 32'hA5A5_A5A5);
        add_request(ils_pkg::OP_FIND, 0, 32'h0000_0001);
        add_request(ils_pkg::OP_REMOVE_MATCH, 0, 32'hFFFF_FFFF);
        add_request(ils_pkg::OP_REMOVE_AT, 2, '0);
        add_request(ils_pkg::OP_REMOVE_AT, 1, '0);
        add_request(ils_pkg::OP_FIND, 0, 32'h0000_0000);
        add_request(ils_pkg::OP_PEEK, 0, '0);
        add_request(ils_pkg::OP_POP, 0, '0);
        add_request(ils_pkg::OP_POP, 0, '0);

        // random runs of fills, drains and mixed traffic
        n = 0;
        while (n < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(12, 22);
            for (int k = 0; k < len; k++) begin
                r   = $urandom_range(0, 99);
                pos = (r < 90) ? $urandom_range(0, ils_pkg::DEPTH) : $urandom_range(0, 31);
                if (kind < 3) begin
                    op  = (r < 70) ? ils_pkg::OP_PUSH : ils_pkg::OP_INSERT;
                    pos = (r < 95) ? $urandom_range(0, 4) : pos;
                end else if (kind < 5) begin
                    case ($urandom_range(0, 3))
                        0: op = ils_pkg::OP_POP;
                        1: op = ils_pkg::OP_PEEK;
                        2: op = ils_pkg::OP_REMOVE_MATCH;
                        default: op = ils_pkg::OP_REMOVE_AT;
                    endcase
                    pos = (r < 80) ? $urandom_range(0, 4) : pos;
                end else if (r < 4) begin
                    op = 4'($urandom_range(int'(ils_pkg::OP_REMOVE_MATCH) + 1, 15));
                end else begin
                    op = 4'($urandom_range(int'(ils_pkg::OP_PUSH),
                                           int'(ils_pkg::OP_REMOVE_MATCH)));
                end
                add_request(op, pos, pick_value(), (n % 500) == 0);
                n++;
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_q.size() != 0 || in_valid || sent_cnt != recv_cnt) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("tb_indexed_lifo_stack: PASS");
        end else begin
            $display("tb_indexed_lifo_stack: FAIL");
        end
        $finish;
    end

endmodule
